[rtl/core/hts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the heightfield triangle sampler.
// No dependencies; imported by the top level.
package hts_pkg;

    // request kinds carried in req_type
    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TILE_UNITS = 2'd0,
        CFG_GRID_X     = 2'd1,
        CFG_GRID_Z     = 2'd2
    } cfg_idx_t;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 9;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    typedef struct packed {
        logic               req_type;
        logic [8:0]         point_x;
        logic [8:0]         point_z;
        logic signed [15:0] point_height;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_z;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] height_out;
        logic               in_range;
    } out_item_t;

endpackage

[rtl/core/hts_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/heightfield_triangle_sampler.sv]
`timescale 1ns / 1ps
// Heightfield triangle sampler: one beat per cycle while in_stall is low; the
// position divider and the result divider together take 39 stages, one quotient
// bit each, for any FRAC_BITS. Corner heights sit in four parity banks so all
// four corners are read in the same cycle. Reset clears the pipeline valid bits
// and the output buffer and sets the config registers to tile units 1 and grid
// sizes 256; the height store is not cleared and corners are undefined until loaded.
module heightfield_triangle_sampler #(
    parameter int MAX_TILES = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hts_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [hts_pkg::CFG_DW-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hts_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hts_pkg::out_item_t            out_data
);

    import hts_pkg::*;

    localparam int QW    = 23 - FRAC_BITS;           // integer bits of a position
    localparam int UW    = 8 + FRAC_BITS;            // in-tile offset / weight width
    localparam int TW    = $clog2(MAX_TILES + 1);
    localparam int GW    = (TW > 9) ? TW : 9;
    localparam int CW    = (QW > GW) ? QW : GW;
    localparam int HALF  = MAX_TILES / 2 + 1;
    localparam int DEPTH = HALF * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = UW + 17;
    localparam int NW    = UW + 19;
    localparam int QH    = FRAC_BITS + 16;           // result quotient bits
    localparam int HW    = (QH + 1 > 25) ? QH + 1 : 25;

    localparam logic signed [HW-1:0] H_MAX = HW'(OUT_MAX);
    localparam logic signed [HW-1:0] H_MIN = HW'(OUT_MIN);

    typedef struct packed {
        logic                 qry;
        logic                 neg;
        logic                 ld_ok;
        logic [1:0]           ld_bank;
        logic [AW-1:0]        ld_addr;
        logic signed [15:0]   ld_h;
    } meta_t;

    typedef struct packed {
        logic                 vld;
        meta_t                m;
        logic [QW-1:0]        nx;
        logic [QW-1:0]        nz;
        logic [7:0]           rx;
        logic [7:0]           rz;
        logic [QW-1:0]        qx;
        logic [QW-1:0]        qz;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fz;
    } pdiv_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic                 lp;
        logic                 tp;
        logic [UW-1:0]        u;
        logic [UW-1:0]        v;
        logic                 ld_ok;
        logic [1:0]           ld_bank;
        logic signed [15:0]   ld_h;
        logic [3:0][AW-1:0]   addr;
    } addr_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic                 lp;
        logic                 tp;
        logic [UW-1:0]        u;
        logic [UW-1:0]        v;
    } rd_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic                 diag;
        logic                 vgtu;
        logic                 sumlt;
        logic [UW-1:0]        u;
        logic [UW-1:0]        v;
        logic signed [15:0]   htl;
        logic signed [15:0]   htr;
        logic signed [15:0]   hbl;
        logic signed [15:0]   hbr;
    } tri_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic [UW-1:0]        w0;
        logic [UW-1:0]        w1;
        logic [UW-1:0]        w2;
        logic signed [15:0]   h0;
        logic signed [15:0]   h1;
        logic signed [15:0]   h2;
    } wgt_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic signed [PW-1:0] p0;
        logic signed [PW-1:0] p1;
        logic signed [PW-1:0] p2;
    } prod_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic signed [NW-1:0] a;
        logic signed [NW-1:0] b;
    } psum_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic signed [NW-1:0] n2;
    } num_t;

    typedef struct packed {
        logic                 vld;
        logic                 qry;
        logic                 oor;
        logic                 neg;
        logic [8:0]           rem;
        logic [QH-1:0]        n;
        logic [QH-1:0]        q;
    } hdiv_t;

    // ---------------- configuration ----------------
    logic [7:0] tile_units_reg;
    logic [8:0] grid_x_reg;
    logic [8:0] grid_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_units_reg <= 8'd1;
            grid_x_reg     <= 9'd256;
            grid_z_reg     <= 9'd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_TILE_UNITS: tile_units_reg <= cfg_wdata[7:0];
                CFG_GRID_X:     grid_x_reg     <= cfg_wdata;
                CFG_GRID_Z:     grid_z_reg     <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    logic [7:0]    teff;
    logic [8:0]    dres;
    logic [UW-1:0] s_val;
    logic [CW-1:0] gx_eff;
    logic [CW-1:0] gz_eff;

    assign teff   = (tile_units_reg == 8'd0) ? 8'd1 : tile_units_reg;
    assign dres   = {teff, 1'b0};
    assign s_val  = UW'(teff) << FRAC_BITS;
    assign gx_eff = (CW'(grid_x_reg) > CW'(MAX_TILES)) ? CW'(MAX_TILES) : CW'(grid_x_reg);
    assign gz_eff = (CW'(grid_z_reg) > CW'(MAX_TILES)) ? CW'(MAX_TILES) : CW'(grid_z_reg);

    // ---------------- pipeline control ----------------
    logic      adv;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    assign adv      = !skid_valid_reg;
    assign in_stall = !adv;

    // ---------------- input stage + position divider ----------------
    pdiv_t pd_reg  [QW+1];
    pdiv_t pd_next [QW];
    pdiv_t pd_in;

    always_comb
    begin
        pd_in            = '0;
        pd_in.vld        = in_valid;
        pd_in.m.qry      = (in_data.req_type == REQ_QUERY);
        pd_in.m.neg      = in_data.pos_x[23] | in_data.pos_z[23];
        pd_in.m.ld_ok    = (GW'(in_data.point_x) <= GW'(MAX_TILES))
                        && (GW'(in_data.point_z) <= GW'(MAX_TILES));
        pd_in.m.ld_bank  = {in_data.point_z[0], in_data.point_x[0]};
        pd_in.m.ld_addr  = AW'(AW'(in_data.point_z >> 1) * AW'(HALF)
                              + AW'(in_data.point_x >> 1));
        pd_in.m.ld_h     = in_data.point_height;
        pd_in.nx         = in_data.pos_x[22:FRAC_BITS];
        pd_in.nz         = in_data.pos_z[22:FRAC_BITS];
        pd_in.fx         = in_data.pos_x[FRAC_BITS-1:0];
        pd_in.fz         = in_data.pos_z[FRAC_BITS-1:0];
    end

    // one quotient bit per stage for x and z
    always_comb
    begin
        logic [8:0] tx;
        logic [8:0] tz;
        logic       bx;
        logic       bz;
        for (int k = 0; k < QW; k++)
        begin
            pd_next[k] = pd_reg[k];
            tx = {pd_reg[k].rx, pd_reg[k].nx[QW-1]};
            tz = {pd_reg[k].rz, pd_reg[k].nz[QW-1]};
            bx = (tx >= {1'b0, teff});
            bz = (tz >= {1'b0, teff});
            pd_next[k].rx = bx ? 8'(tx - {1'b0, teff}) : tx[7:0];
            pd_next[k].rz = bz ? 8'(tz - {1'b0, teff}) : tz[7:0];
            pd_next[k].qx = {pd_reg[k].qx[QW-2:0], bx};
            pd_next[k].qz = {pd_reg[k].qz[QW-2:0], bz};
            pd_next[k].nx = pd_reg[k].nx << 1;
            pd_next[k].nz = pd_reg[k].nz << 1;
        end
    end

    // ---------------- range check and bank addresses ----------------
    addr_t ar_reg;
    addr_t ar_next;

    always_comb
    begin
        logic [TW-1:0] left;
        logic [TW-1:0] top;
        logic [TW-1:0] cx;
        logic [TW-1:0] cz;
        left = TW'(pd_reg[QW].qx);
        top  = TW'(pd_reg[QW].qz);
        ar_next         = '0;
        ar_next.vld     = pd_reg[QW].vld;
        ar_next.qry     = pd_reg[QW].m.qry;
        ar_next.oor     = pd_reg[QW].m.neg
                       || (CW'(pd_reg[QW].qx) >= gx_eff)
                       || (CW'(pd_reg[QW].qz) >= gz_eff);
        ar_next.lp      = left[0];
        ar_next.tp      = top[0];
        ar_next.u       = {pd_reg[QW].rx, pd_reg[QW].fx};
        ar_next.v       = {pd_reg[QW].rz, pd_reg[QW].fz};
        ar_next.ld_ok   = pd_reg[QW].m.ld_ok;
        ar_next.ld_bank = pd_reg[QW].m.ld_bank;
        ar_next.ld_h    = pd_reg[QW].m.ld_h;
        for (int b = 0; b < 4; b++)
        begin
            // corner of this tile whose coordinate parities match bank b
            cx = left + TW'(left[0] ^ b[0]);
            cz = top + TW'(top[0] ^ b[1]);
            if (!pd_reg[QW].m.qry)
                ar_next.addr[b] = pd_reg[QW].m.ld_addr;
            else if (ar_next.oor)
                ar_next.addr[b] = '0;
            else
                ar_next.addr[b] = AW'(AW'(cz >> 1) * AW'(HALF) + AW'(cx >> 1));
        end
    end

    // ---------------- height banks ----------------
    logic [3:0]       bank_we;
    logic [3:0][15:0] bank_q;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        assign bank_we[b] = adv && ar_reg.vld && !ar_reg.qry && ar_reg.ld_ok
                         && (ar_reg.ld_bank == 2'(b));
        hts_ram #(
            .WIDTH (16),
            .DEPTH (DEPTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (bank_we[b]),
            .wr_addr (ar_reg.addr[b]),
            .wr_data (ar_reg.ld_h),
            .rd_en   (adv && ar_reg.vld && ar_reg.qry),
            .rd_addr (ar_reg.addr[b]),
            .rd_data (bank_q[b])
        );
    end

    rd_t rd_reg;
    rd_t rd_next;

    always_comb
    begin
        rd_next     = '0;
        rd_next.vld = ar_reg.vld;
        rd_next.qry = ar_reg.qry;
        rd_next.oor = ar_reg.oor;
        rd_next.lp  = ar_reg.lp;
        rd_next.tp  = ar_reg.tp;
        rd_next.u   = ar_reg.u;
        rd_next.v   = ar_reg.v;
    end

    // ---------------- diagonal and triangle choice ----------------
    tri_t tr_reg;
    tri_t tr_next;

    always_comb
    begin
        logic [15:0]        top_e;
        logic [15:0]        top_o;
        logic [15:0]        bot_e;
        logic [15:0]        bot_o;
        logic signed [16:0] d_a;
        logic signed [16:0] d_b;
        logic [16:0]        abs_a;
        logic [16:0]        abs_b;
        // bank index is {z parity, x parity}
        top_e = rd_reg.tp ? bank_q[2] : bank_q[0];
        top_o = rd_reg.tp ? bank_q[3] : bank_q[1];
        bot_e = rd_reg.tp ? bank_q[0] : bank_q[2];
        bot_o = rd_reg.tp ? bank_q[1] : bank_q[3];
        tr_next     = '0;
        tr_next.vld = rd_reg.vld;
        tr_next.qry = rd_reg.qry;
        tr_next.oor = rd_reg.oor;
        tr_next.u   = rd_reg.u;
        tr_next.v   = rd_reg.v;
        tr_next.htl = $signed(rd_reg.lp ? top_o : top_e);
        tr_next.htr = $signed(rd_reg.lp ? top_e : top_o);
        tr_next.hbl = $signed(rd_reg.lp ? bot_o : bot_e);
        tr_next.hbr = $signed(rd_reg.lp ? bot_e : bot_o);
        d_a   = 17'(tr_next.htr) - 17'(tr_next.hbl);
        d_b   = 17'(tr_next.htl) - 17'(tr_next.hbr);
        abs_a = d_a[16] ? 17'(-d_a) : 17'(d_a);
        abs_b = d_b[16] ? 17'(-d_b) : 17'(d_b);
        tr_next.diag  = (abs_a > abs_b);
        tr_next.vgtu  = (rd_reg.v > rd_reg.u);
        tr_next.sumlt = ({1'b0, rd_reg.u} + {1'b0, rd_reg.v}) < {1'b0, s_val};
    end

    // ---------------- weights ----------------
    wgt_t wg_reg;
    wgt_t wg_next;

    always_comb
    begin
        logic sel;
        sel         = tr_reg.diag ? tr_reg.vgtu : tr_reg.sumlt;
        wg_next     = '0;
        wg_next.vld = tr_reg.vld;
        wg_next.qry = tr_reg.qry;
        wg_next.oor = tr_reg.oor;
        unique case ({tr_reg.diag, sel})
            2'b11:
            begin
                wg_next.w0 = s_val - tr_reg.v;            wg_next.h0 = tr_reg.htl;
                wg_next.w1 = tr_reg.v - tr_reg.u;         wg_next.h1 = tr_reg.hbl;
                wg_next.w2 = tr_reg.u;                    wg_next.h2 = tr_reg.hbr;
            end
            2'b10:
            begin
                wg_next.w0 = s_val - tr_reg.u;            wg_next.h0 = tr_reg.htl;
                wg_next.w1 = tr_reg.u - tr_reg.v;         wg_next.h1 = tr_reg.hbr;
                wg_next.w2 = tr_reg.v;                    wg_next.h2 = tr_reg.htr;
            end
            2'b01:
            begin
                wg_next.w0 = s_val - tr_reg.u - tr_reg.v; wg_next.h0 = tr_reg.htl;
                wg_next.w1 = tr_reg.v;                    wg_next.h1 = tr_reg.hbl;
                wg_next.w2 = tr_reg.u;                    wg_next.h2 = tr_reg.htr;
            end
            default:
            begin
                wg_next.w0 = s_val - tr_reg.v;            wg_next.h0 = tr_reg.htr;
                wg_next.w1 = s_val - tr_reg.u;            wg_next.h1 = tr_reg.hbl;
                wg_next.w2 = tr_reg.u + tr_reg.v - s_val; wg_next.h2 = tr_reg.hbr;
            end
        endcase
    end

    // ---------------- products, sum ----------------
    prod_t pr_reg;
    prod_t pr_next;
    psum_t ps_reg;
    psum_t ps_next;
    num_t  nm_reg;
    num_t  nm_next;

    always_comb
    begin
        pr_next     = '0;
        pr_next.vld = wg_reg.vld;
        pr_next.qry = wg_reg.qry;
        pr_next.oor = wg_reg.oor;
        pr_next.p0  = $signed({1'b0, wg_reg.w0}) * wg_reg.h0;
        pr_next.p1  = $signed({1'b0, wg_reg.w1}) * wg_reg.h1;
        pr_next.p2  = $signed({1'b0, wg_reg.w2}) * wg_reg.h2;

        ps_next     = '0;
        ps_next.vld = pr_reg.vld;
        ps_next.qry = pr_reg.qry;
        ps_next.oor = pr_reg.oor;
        ps_next.a   = NW'(pr_reg.p0) + NW'(pr_reg.p1);
        ps_next.b   = NW'(pr_reg.p2);

        // 2*num + t, later divided by 2t with floor: round half up of num/t
        nm_next     = '0;
        nm_next.vld = ps_reg.vld;
        nm_next.qry = ps_reg.qry;
        nm_next.oor = ps_reg.oor;
        nm_next.n2  = ((ps_reg.a + ps_reg.b) <<< 1) + NW'($signed({1'b0, teff}));
    end

    // ---------------- result divider ----------------
    hdiv_t hd_reg  [QH+1];
    hdiv_t hd_next [QH];
    hdiv_t hd_in;

    always_comb
    begin
        logic [NW-1:0] mag;
        logic [9:0]    tr;
        logic          bq;
        hd_in     = '0;
        hd_in.vld = nm_reg.vld;
        hd_in.qry = nm_reg.qry;
        hd_in.oor = nm_reg.oor;
        hd_in.neg = nm_reg.n2[NW-1];
        mag       = hd_in.neg ? NW'(-nm_reg.n2) : NW'(nm_reg.n2);
        // high part is already below 2t since |num/t| < 2^(QH-1)
        hd_in.rem = mag[QH+8:QH];
        hd_in.n   = mag[QH-1:0];
        for (int k = 0; k < QH; k++)
        begin
            hd_next[k]     = hd_reg[k];
            tr             = {hd_reg[k].rem, hd_reg[k].n[QH-1]};
            bq             = (tr >= {1'b0, dres});
            hd_next[k].rem = bq ? 9'(tr - {1'b0, dres}) : tr[8:0];
            hd_next[k].q   = {hd_reg[k].q[QH-2:0], bq};
            hd_next[k].n   = hd_reg[k].n << 1;
        end
    end

    // ---------------- final rounding fix-up and saturation ----------------
    out_item_t        res;
    logic             push;
    logic [HW-1:0]    qext;
    logic signed [HW-1:0] hq;

    always_comb
    begin
        qext = HW'(hd_reg[QH].q) + HW'(hd_reg[QH].neg && (hd_reg[QH].rem != 9'd0));
        hq   = hd_reg[QH].neg ? -$signed(qext) : $signed(qext);
        res  = '0;
        if (!hd_reg[QH].oor)
        begin
            res.in_range = 1'b1;
            if (hq > H_MAX)
                res.height_out = 24'(H_MAX);
            else if (hq < H_MIN)
                res.height_out = 24'(H_MIN);
            else
                res.height_out = 24'(hq);
        end
    end

    assign push = adv && hd_reg[QH].vld && hd_reg[QH].qry;

    // ---------------- stage registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                pd_reg[k] <= '0;
            end
            ar_reg <= '0;
            rd_reg <= '0;
            tr_reg <= '0;
            wg_reg <= '0;
            pr_reg <= '0;
            ps_reg <= '0;
            nm_reg <= '0;
            for (int k = 0; k <= QH; k++)
            begin
                hd_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            pd_reg[0] <= pd_in;
            for (int k = 0; k < QW; k++)
            begin
                pd_reg[k+1] <= pd_next[k];
            end
            ar_reg    <= ar_next;
            rd_reg    <= rd_next;
            tr_reg    <= tr_next;
            wg_reg    <= wg_next;
            pr_reg    <= pr_next;
            ps_reg    <= ps_next;
            nm_reg    <= nm_next;
            hd_reg[0] <= hd_in;
            for (int k = 0; k < QH; k++)
            begin
                hd_reg[k+1] <= hd_next[k];
            end
        end
    end

    // ---------------- output register with skid entry ----------------
    logic pop;
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
                out_data_reg  <= res;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output beat");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid entry not drained after output pop");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.in_range) |-> (out_data.height_out == 24'sd0))
        else $error("out-of-range beat with nonzero height");

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("more than one bank written in a cycle");

endmodule

[tb/sv/tb_heightfield_triangle_sampler.sv]
`timescale 1ns / 1ps
// Testbench for heightfield_triangle_sampler: loads corners, queries heights and
// checks every result against an in-bench height predictor. Depends on hts_pkg.
module tb_heightfield_triangle_sampler;
    import hts_pkg::*;

    localparam int MAXT = 256;
    localparam int SIDE = MAXT + 1;
    localparam int LATENCY = 48;
    localparam int WD_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int n_queries = 0;
    int n_loads = 0;
    int n_in_range = 0;
    bit timed_out = 1'b0;

    always #5 clk = ~clk;

    heightfield_triangle_sampler DUT (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    class height_scoreboard;
        logic signed [15:0] corners [SIDE*SIDE];
        logic [7:0] tile_units;
        logic [8:0] tiles_x;
        logic [8:0] tiles_z;
        out_item_t pending[$];
        int mismatches;

        function new();
            tile_units = 8'd1;
            tiles_x = 9'd256;
            tiles_z = 9'd256;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_TILE_UNITS: tile_units = val[7:0];
                CFG_GRID_X:     tiles_x = val;
                CFG_GRID_Z:     tiles_z = val;
                default: ;
            endcase
        endfunction

        function longint corner(int x, int z);
            return longint'(corners[z*SIDE + x]);
        endfunction

        function void note_input(in_item_t it);
            longint px, pz, s, u, v, num, h, t, tl, tr, bl, br, q;
            longint gx, gz;
            int left, top;
            out_item_t r;
            if (it.req_type == REQ_LOAD) begin
                if (it.point_x <= MAXT && it.point_z <= MAXT)
                    corners[it.point_z*SIDE + it.point_x] = it.point_height;
                return;
            end
            r = '0;
            px = longint'(it.pos_x);
            pz = longint'(it.pos_z);
            t = (tile_units == 0) ? 1 : tile_units;
            gx = (tiles_x > MAXT) ? MAXT : tiles_x;
            gz = (tiles_z > MAXT) ? MAXT : tiles_z;
            s = t << 8;
            if (px >= 0 && pz >= 0 && px / s < gx && pz / s < gz) begin
                left = int'(px / s);
                top = int'(pz / s);
                u = px - left * s;
                v = pz - top * s;
                tl = corner(left, top);
                tr = corner(left + 1, top);
                bl = corner(left, top + 1);
                br = corner(left + 1, top + 1);
                if ((tr > bl ? tr - bl : bl - tr) > (tl > br ? tl - br : br - tl)) begin
                    if (v > u) num = (s - v) * tl + (v - u) * bl + u * br;
                    else       num = (s - u) * tl + (u - v) * br + v * tr;
                end else begin
                    if (u + v < s) num = (s - u - v) * tl + v * bl + u * tr;
                    else           num = (s - v) * tr + (s - u) * bl + (u + v - s) * br;
                end
                // round half up: floor((2n + t) / 2t)
                q = (2 * num + t) / (2 * t);
                if (((2 * num + t) % (2 * t)) != 0 && (2 * num + t) < 0) q = q - 1;
                h = q;
                if (h > OUT_MAX) h = OUT_MAX;
                if (h < OUT_MIN) h = OUT_MIN;
                r.height_out = h[23:0];
                r.in_range = 1'b1;
            end
            pending = {pending, r};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: height %0d in_range %0b",
                             got.height_out, got.in_range);
                return;
            end
            want = pending.pop_front();
            if (got.height_out !== want.height_out || got.in_range !== want.in_range) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp height %0d rng %0b, got height %0d rng %0b",
                             want.height_out, want.in_range, got.height_out, got.in_range);
            end
        endfunction
    endclass

    height_scoreboard sb;

    // receiver side: random stalls, result checking
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_data);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("tb_heightfield_triangle_sampler: errors");
            $finish;
        end
    end

    // valid stays high into the next beat; idle gaps and drain drop it
    task automatic send_beat(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(it);
        if (it.req_type == REQ_QUERY) n_queries++;
        else n_loads++;
    endtask

    task automatic load_corner(int x, int z, logic signed [15:0] h);
        in_item_t it;
        it = '0;
        it.req_type = REQ_LOAD;
        it.point_x = x[8:0];
        it.point_z = z[8:0];
        it.point_height = h;
        it.pos_x = 24'($urandom);
        it.pos_z = 24'($urandom);
        send_beat(it);
    endtask

    task automatic query_at(logic signed [23:0] x, logic signed [23:0] z);
        in_item_t it;
        it = '0;
        it.req_type = REQ_QUERY;
        it.pos_x = x;
        it.pos_z = z;
        it.point_x = 9'($urandom);
        it.point_z = 9'($urandom);
        it.point_height = 16'($urandom);
        send_beat(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic set_config(int t, int gx, int gz);
        write_reg(CFG_TILE_UNITS, t[8:0]);
        write_reg(CFG_GRID_X, gx[8:0]);
        write_reg(CFG_GRID_Z, gz[8:0]);
        cfg_wr_en <= 1'b0;
    endtask

    // random query: mostly inside the in-use grid, some beyond it or negative
    task automatic random_query();
        int t, gx, gz, span_x, span_z, sel;
        t = (sb.tile_units == 0) ? 1 : sb.tile_units;
        gx = (sb.tiles_x > MAXT) ? MAXT : sb.tiles_x;
        gz = (sb.tiles_z > MAXT) ? MAXT : sb.tiles_z;
        span_x = gx * t * 256;
        span_z = gz * t * 256;
        sel = $urandom_range(99);
        if (sel < 80 && gx > 0 && gz > 0)
            query_at(24'($urandom_range(span_x - 1)), 24'($urandom_range(span_z - 1)));
        else if (sel < 85 && gx > 0 && gz > 0)
            query_at(24'(span_x - 1), 24'(span_z - 1));
        else
            query_at(24'($urandom), 24'($urandom));
    endtask

    // fill every corner the current setting can read, using only the used area
    task automatic fill_grid(int gx, int gz, int mode);
        logic signed [15:0] h;
        for (int z = 0; z <= gz; z++) begin
            for (int x = 0; x <= gx; x++) begin
                case (mode)
                    0: h = 16'($urandom);
                    1: h = ((x + z) % 2) ? 16'sh7fff : 16'sh8000;
                    default: h = 16'($urandom_range(200) - 100);
                endcase
                load_corner(x, z, h);
            end
        end
    endtask

    task automatic random_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15) begin
                int gx, gz;
                gx = (sb.tiles_x > MAXT) ? MAXT : sb.tiles_x;
                gz = (sb.tiles_z > MAXT) ? MAXT : sb.tiles_z;
                if ($urandom_range(9) == 0)
                    load_corner($urandom_range(511, 257), $urandom_range(511),
                                16'($urandom));
                else
                    load_corner($urandom_range(gx), $urandom_range(gz), 16'($urandom));
            end else
                random_query();
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small grid at reset tile size, then the edge cases
        set_config(1, 2, 2);
        fill_grid(2, 2, 1);
        query_at(24'sd0, 24'sd0);
        query_at(24'sd128, 24'sd128);
        query_at(24'sd511, 24'sd511);
        query_at(24'sd512, 24'sd0);
        query_at(-24'sd1, 24'sd10);
        query_at(24'sd10, 24'sh800000);
        query_at(24'sh7fffff, 24'sh7fffff);
        load_corner(300, 5, 16'sh1234);
        load_corner(1, 0, 16'sd40);
        load_corner(0, 1, 16'sd0);
        load_corner(0, 0, 16'sd20);
        load_corner(1, 1, 16'sd20);
        query_at(24'sd100, 24'sd100);
        query_at(24'sd50, 24'sd200);
        query_at(24'sd200, 24'sd50);
        drain();
        set_config(0, 0, 3);
        query_at(24'sd10, 24'sd10);
        drain();
        set_config(255, 300, 511);
        query_at(24'sd1000, 24'sd1000);
        drain();

        // random phases over several settings
        set_config(1, 4, 4);
        fill_grid(4, 4, 0);
        random_phase(150, 0, 0);
        set_config(255, 3, 2);
        fill_grid(3, 2, 0);
        random_phase(150, 85, 0);
        set_config(7, 8, 5);
        fill_grid(8, 5, 2);
        random_phase(150, 0, 85);
        set_config(0, 2, 6);
        fill_grid(2, 6, 1);
        random_phase(120, 7, 7);
        set_config(256, 256, 256);
        fill_grid(1, 1, 0);
        drain();
        set_config(1, 1, 1);
        random_phase(100, 0, 0);
        set_config(3, 5, 3);
        fill_grid(5, 3, 0);
        random_phase(265, 30, 30);

        drain();
        $display("covered %0d loads and %0d queries (%0d in range) across several settings",
                 n_loads, n_queries, n_in_range);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_heightfield_triangle_sampler: clean");
        else
            $display("tb_heightfield_triangle_sampler: errors");
        $finish;
    end

    always @(posedge clk)
        if (out_valid && !out_stall && out_data.in_range) n_in_range <= n_in_range + 1;

endmodule

[files.f]
rtl/core/hts_pkg.sv
rtl/core/hts_ram.sv
rtl/core/heightfield_triangle_sampler.sv
tb/sv/tb_heightfield_triangle_sampler.sv
